### rtl/md5_stream_hasher_defines.svh
// Assertion helpers shared by the MD5 stream hasher RTL.
`ifndef MD5_STREAM_HASHER_DEFINES_SVH
`define MD5_STREAM_HASHER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define MD5SH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define MD5SH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/md5sh_pkg.sv
package md5sh_pkg;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
  } md5sh_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } md5sh_out_t;

  // working variables of the compression
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5sh_work_t;

  localparam logic [1:0] FUNC_ABSORB     = 2'd0;
  localparam logic [1:0] FUNC_ABSORB_FIN = 2'd1;
  localparam logic [1:0] FUNC_FIN        = 2'd2;

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam logic [5:0] BLOCK_LAST  = 6'd63;

  function automatic logic [31:0] chain_init(input logic [1:0] k);
    logic [31:0] v;
    case (k)
      2'd0:    v = 32'h67452301;
      2'd1:    v = 32'hefcdab89;
      2'd2:    v = 32'h98badcfe;
      default: v = 32'h10325476;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [3:0] idx);
    logic [4:0] s;
    case (idx)
      4'd0:    s = 5'd7;
      4'd1:    s = 5'd12;
      4'd2:    s = 5'd17;
      4'd3:    s = 5'd22;
      4'd4:    s = 5'd5;
      4'd5:    s = 5'd9;
      4'd6:    s = 5'd14;
      4'd7:    s = 5'd20;
      4'd8:    s = 5'd4;
      4'd9:    s = 5'd11;
      4'd10:   s = 5'd16;
      4'd11:   s = 5'd23;
      4'd12:   s = 5'd6;
      4'd13:   s = 5'd10;
      4'd14:   s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

endpackage

### rtl/md5sh_round.sv
module md5sh_round import md5sh_pkg::*; (
  input  logic [5:0]  rnd,
  input  md5sh_work_t work,
  input  logic [31:0] msg_word,
  output logic [3:0]  msg_idx,
  output logic [31:0] b_new
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [31:0] rotated;
  logic [4:0]  s;
  logic [5:0]  s_inv;
  logic [3:0]  r4;

  always_comb begin
    r4 = rnd[3:0];
    case (rnd[5:4])
      2'd0: begin
        f       = (work.b & work.c) | (~work.b & work.d);
        msg_idx = r4;
      end
      2'd1: begin
        f       = (work.b & work.d) | (work.c & ~work.d);
        msg_idx = (r4 << 2) + r4 + 4'd1;
      end
      2'd2: begin
        f       = work.b ^ work.c ^ work.d;
        msg_idx = (r4 << 1) + r4 + 4'd5;
      end
      default: begin
        f       = work.c ^ (work.b | ~work.d);
        msg_idx = (r4 << 3) - r4;
      end
    endcase
    sum     = work.a + f + round_k(rnd) + msg_word;
    s       = rot_amt({rnd[5:4], rnd[1:0]});
    // shift amounts are never zero, so the right shift stays below 32
    s_inv   = 6'd32 - {1'b0, s};
    rotated = (sum << s) | (sum >> s_inv);
    b_new   = work.b + rotated;
  end

endmodule

### rtl/md5_stream_hasher.sv
// An absorbed byte is stored in the block buffer; the byte that fills a block starts
// 64 rounds through the single round unit, one per cycle, then the chaining add.
// Finalize writes 9 to 72 padding and length bytes at one a cycle, compresses one or
// two blocks, then offers the four digest words, one a cycle while out_stall is low.
// Throughput: one byte a cycle while idle; in_stall is high whenever the hasher is not idle.
// Reset: chaining words to the MD5 initial values, byte count and sequencer cleared.
`include "md5_stream_hasher_defines.svh"

module md5_stream_hasher import md5sh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  md5sh_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output md5sh_out_t out_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [60:0] total_r, total_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [1:0]  widx_r, widx_nxt;
  logic        fin_r, fin_nxt;
  logic        first_r, first_nxt;
  logic        len_ok_r, len_ok_nxt;
  logic        last_blk_r, last_blk_nxt;
  md5sh_work_t work_r, work_nxt;
  logic [31:0] chain_r [4];
  logic [31:0] chain_nxt [4];
  logic [31:0] blk_r [16];

  logic        blk_we;
  logic [7:0]  blk_byte;
  logic [7:0]  pad_byte;
  logic [63:0] len_bits;
  logic [7:0]  len_byte;
  logic [3:0]  msg_idx;
  logic [31:0] b_new;
  logic        in_acc;
  logic        out_acc;

  md5sh_round u_round (
    .rnd      (rnd_r),
    .work     (work_r),
    .msg_word (blk_r[msg_idx]),
    .msg_idx  (msg_idx),
    .b_new    (b_new)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state_r == ST_OUT);
  assign out_acc   = out_valid && !out_stall;

  assign out_data.digest_word = chain_r[widx_r];
  assign out_data.word_index  = widx_r;
  assign out_data.last_word   = (widx_r == 2'd3);

  // message length in bits, little-endian bytes at positions 56..63
  assign len_bits = {total_r, 3'b000};
  assign len_byte = len_bits[{pos_r[2:0], 3'b000} +: 8];
  assign pad_byte = first_r ? PAD_BYTE :
                    ((len_ok_r && (pos_r >= LEN_POS)) ? len_byte : 8'h00);

  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    total_nxt    = total_r;
    rnd_nxt      = rnd_r;
    widx_nxt     = widx_r;
    fin_nxt      = fin_r;
    first_nxt    = first_r;
    len_ok_nxt   = len_ok_r;
    last_blk_nxt = last_blk_r;
    work_nxt     = work_r;
    for (int k = 0; k < 4; k++) begin
      chain_nxt[k] = chain_r[k];
    end
    blk_we   = 1'b0;
    blk_byte = in_data.data_byte;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.func)
            FUNC_ABSORB, FUNC_ABSORB_FIN: begin
              blk_we       = 1'b1;
              pos_nxt      = pos_r + 6'd1;
              total_nxt    = total_r + 61'd1;
              last_blk_nxt = 1'b0;
              len_ok_nxt   = 1'b0;
              if (in_data.func == FUNC_ABSORB_FIN) begin
                fin_nxt   = 1'b1;
                first_nxt = 1'b1;
                state_nxt = ST_PAD;
              end
              if (pos_r == BLOCK_LAST) begin
                state_nxt = ST_COMP;
              end
            end
            FUNC_FIN: begin
              fin_nxt      = 1'b1;
              first_nxt    = 1'b1;
              len_ok_nxt   = 1'b0;
              last_blk_nxt = 1'b0;
              state_nxt    = ST_PAD;
            end
            default: ;
          endcase
        end
      end
      ST_PAD: begin
        blk_we    = 1'b1;
        blk_byte  = pad_byte;
        pos_nxt   = pos_r + 6'd1;
        first_nxt = 1'b0;
        // marker below the length field: length goes in this block
        if (first_r && (pos_r < LEN_POS)) begin
          len_ok_nxt = 1'b1;
        end
        if (pos_r == BLOCK_LAST) begin
          last_blk_nxt = len_ok_r;
          len_ok_nxt   = 1'b1;
          state_nxt    = ST_COMP;
        end
      end
      ST_COMP: begin
        work_nxt.a = work_r.d;
        work_nxt.b = b_new;
        work_nxt.c = work_r.b;
        work_nxt.d = work_r.c;
        rnd_nxt    = rnd_r + 6'd1;
        if (rnd_r == BLOCK_LAST) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        chain_nxt[0] = chain_r[0] + work_r.a;
        chain_nxt[1] = chain_r[1] + work_r.b;
        chain_nxt[2] = chain_r[2] + work_r.c;
        chain_nxt[3] = chain_r[3] + work_r.d;
        widx_nxt     = 2'd0;
        if (last_blk_r) begin
          state_nxt = ST_OUT;
        end else if (fin_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          widx_nxt = widx_r + 2'd1;
          if (widx_r == 2'd3) begin
            for (int k = 0; k < 4; k++) begin
              chain_nxt[k] = chain_init(2'(k));
            end
            total_nxt  = '0;
            fin_nxt    = 1'b0;
            last_blk_nxt = 1'b0;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // a block is full: load the working variables for round 0
    if (state_nxt == ST_COMP && state_r != ST_COMP) begin
      rnd_nxt    = '0;
      work_nxt.a = chain_r[0];
      work_nxt.b = chain_r[1];
      work_nxt.c = chain_r[2];
      work_nxt.d = chain_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pos_r      <= '0;
      total_r    <= '0;
      rnd_r      <= '0;
      widx_r     <= '0;
      fin_r      <= 1'b0;
      first_r    <= 1'b0;
      len_ok_r   <= 1'b0;
      last_blk_r <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        chain_r[k] <= chain_init(2'(k));
      end
    end else begin
      state_r    <= state_nxt;
      pos_r      <= pos_nxt;
      total_r    <= total_nxt;
      rnd_r      <= rnd_nxt;
      widx_r     <= widx_nxt;
      fin_r      <= fin_nxt;
      first_r    <= first_nxt;
      len_ok_r   <= len_ok_nxt;
      last_blk_r <= last_blk_nxt;
      for (int k = 0; k < 4; k++) begin
        chain_r[k] <= chain_nxt[k];
      end
    end
  end

  // datapath: no reset
  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    if (blk_we) begin
      blk_r[pos_r[5:2]][{pos_r[1:0], 3'b000} +: 8] <= blk_byte;
    end
  end

  `MD5SH_ASSERT_SAME(a_digest_on_boundary, out_valid, (pos_r == 6'd0) && in_stall, "digest offered off a block boundary or while accepting input")
  `MD5SH_ASSERT_NEXT(a_round_wrap, (state_r == ST_COMP) && (rnd_r == BLOCK_LAST), state_r == ST_ADD, "compression did not end after the last round")
  `MD5SH_ASSERT_NEXT(a_idle_after_digest, out_acc && out_data.last_word, !out_valid && !in_stall && (total_r == 61'd0), "hasher not back to idle after the final digest word")

endmodule

### tb/md5_stream_hasher_tb.sv
`timescale 1ns / 1ps

module md5_stream_hasher_tb;
  import md5sh_pkg::*;

  localparam logic [1:0] FUNC_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT  = 300000;
  localparam int         HOLD_CYCLES  = 600;
  localparam int         SETTLE_CYCLES = 200;
  localparam int         RANDOM_ITEMS = 260;

  // per-round additive constants, round 0 in the top word
  localparam logic [64*32-1:0] SINE_K = {
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [16*5-1:0] ROT_TAB = {
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  localparam logic [4*32-1:0] MD5_IV = {
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  md5sh_in_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  md5sh_out_t out_data;

  // hash state as the block should hold it
  logic [31:0] chain_words [4];
  logic [31:0] block_buf [16];
  logic [60:0] msg_bytes;

  md5sh_out_t digest_q [$];

  bit no_idle = 1'b0;
  int hold_asks = 0;
  int hold_served = 0;
  int n_errors = 0;
  int n_items = 0;
  int n_words = 0;
  int n_msgs = 0;
  int cycle_count = 0;

  md5_stream_hasher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d digest words outstanding",
               cycle_count, digest_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] rol32(logic [31:0] x, int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic void hash_restart();
    for (int k = 0; k < 4; k++)
      chain_words[k] = MD5_IV[(3 - k)*32 +: 32];
    msg_bytes = '0;
  endfunction

  function automatic void hash_compress();
    logic [31:0] a, b, c, d, f, t;
    int g, sh;
    a = chain_words[0];
    b = chain_words[1];
    c = chain_words[2];
    d = chain_words[3];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        f = (b & c) | (~b & d);
        g = r;
      end else if (r < 32) begin
        f = (b & d) | (c & ~d);
        g = (5*r + 1) % 16;
      end else if (r < 48) begin
        f = b ^ c ^ d;
        g = (3*r + 5) % 16;
      end else begin
        f = c ^ (b | ~d);
        g = (7*r) % 16;
      end
      sh = int'(ROT_TAB[(15 - ((r/16)*4 + r%4))*5 +: 5]);
      t = d;
      d = c;
      c = b;
      b = b + rol32(a + f + SINE_K[(63 - r)*32 +: 32] + block_buf[4'(g)], sh);
      a = t;
    end
    chain_words[0] += a;
    chain_words[1] += b;
    chain_words[2] += c;
    chain_words[3] += d;
  endfunction

  function automatic void hash_put_byte(int pos, logic [7:0] v);
    block_buf[4'(pos/4)][(pos%4)*8 +: 8] = v;
    if (pos == 63)
      hash_compress();
  endfunction

  function automatic void hash_absorb(logic [7:0] v);
    hash_put_byte(int'(msg_bytes[5:0]), v);
    msg_bytes = msg_bytes + 61'd1;
  endfunction

  function automatic void hash_finish();
    logic [63:0] bit_len;
    int pos, pad;
    md5sh_out_t w;
    bit_len = {msg_bytes, 3'b000};
    pos = int'(msg_bytes[5:0]);
    pad = (pos < 56) ? 56 - pos : 120 - pos;
    for (int i = 0; i < pad; i++) begin
      hash_put_byte(pos, (i == 0) ? 8'h80 : 8'h00);
      pos = (pos + 1) % 64;
    end
    for (int i = 0; i < 8; i++) begin
      hash_put_byte(pos, bit_len[8*i +: 8]);
      pos = (pos + 1) % 64;
    end
    for (int k = 0; k < 4; k++) begin
      w.digest_word = chain_words[k];
      w.word_index  = 2'(k);
      w.last_word   = (k == 3);
      digest_q.push_back(w);
    end
    n_msgs++;
    hash_restart();
  endfunction

  function automatic void hash_apply(md5sh_in_t it);
    case (it.func)
      FUNC_ABSORB: begin
        hash_absorb(it.data_byte);
      end
      FUNC_ABSORB_FIN: begin
        hash_absorb(it.data_byte);
        hash_finish();
      end
      FUNC_FIN: begin
        hash_finish();
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("[%0t] MISMATCH %s: expected %h, got %h", $realtime, what, want, got);
    n_errors++;
  endtask

  always @(posedge clk) begin : digest_check
    md5sh_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        report_mismatch("digest word with none pending", 32'h0, out_data.digest_word);
      end else begin
        want = digest_q.pop_front();
        n_words++;
        if (out_data.digest_word !== want.digest_word)
          report_mismatch("digest_word", want.digest_word, out_data.digest_word);
        if (out_data.word_index !== want.word_index)
          report_mismatch("word_index", 32'(want.word_index), 32'(out_data.word_index));
        if (out_data.last_word !== want.last_word)
          report_mismatch("last_word", 32'(want.last_word), 32'(out_data.last_word));
      end
    end
  end

  // receiver: random stalls, plus a long hold whenever one is asked for
  initial begin : rx_stall_gen
    int n;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_served) begin
        hold_served++;
        for (n = 0; n < HOLD_CYCLES; n++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= !no_idle && ($urandom_range(99) < 9);
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_item(input logic [1:0] f, input logic [7:0] v);
    md5sh_in_t it;
    it.func = f;
    it.data_byte = v;
    while (!no_idle && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    hash_apply(it);
    if (f != FUNC_UNUSED)
      n_items++;
  endtask

  // len bytes, finalize either folded into the last byte or sent on its own
  task automatic send_message(input int len, input bit fold_fin);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 4)
        send_item(FUNC_UNUSED, 8'($urandom));
      if (i == len - 1 && fold_fin)
        send_item(FUNC_ABSORB_FIN, 8'($urandom));
      else
        send_item(FUNC_ABSORB, 8'($urandom));
    end
    if (len == 0 || !fold_fin)
      send_item(FUNC_FIN, 8'($urandom));
  endtask

  task automatic drain_digests();
    in_valid <= 1'b0;
    while (digest_q.size() != 0)
      @(posedge clk);
  endtask

  function automatic int pick_length();
    int sel;
    sel = $urandom_range(99);
    if (sel < 65)
      return $urandom_range(16);
    else if (sel < 90)
      return $urandom_range(65, 53);   // around the one/two block padding edge
    else
      return $urandom_range(140, 66);
  endfunction

  task automatic test_empty_message();
    send_item(FUNC_FIN, 8'h00);
    send_item(FUNC_FIN, 8'hff);
  endtask

  task automatic test_unused_code();
    send_item(FUNC_UNUSED, 8'h00);
    send_item(FUNC_UNUSED, 8'hff);
    // ignored transaction in the middle of a message must not disturb it
    send_item(FUNC_ABSORB, 8'h5a);
    send_item(FUNC_UNUSED, 8'ha5);
    send_item(FUNC_ABSORB_FIN, 8'h3c);
  endtask

  task automatic test_short_messages();
    send_item(FUNC_ABSORB_FIN, 8'h00);
    send_item(FUNC_ABSORB_FIN, 8'hff);
    send_item(FUNC_ABSORB, 8'hff);
    send_item(FUNC_FIN, 8'h00);
    send_item(FUNC_ABSORB, 8'h61);
    send_item(FUNC_ABSORB, 8'h62);
    send_item(FUNC_ABSORB_FIN, 8'h63);
    drain_digests();
  endtask

  task automatic test_back_pressure();
    hold_asks++;
    for (int m = 0; m < 8; m++)
      send_message(2, 1'b1);
    drain_digests();
  endtask

  task automatic test_streaming_no_gaps();
    int start;
    no_idle = 1'b1;
    start = n_items;
    while (n_items - start < 70)
      send_message(pick_length(), 1'($urandom_range(1)));
    drain_digests();
    no_idle = 1'b0;
  endtask

  task automatic test_random_messages();
    int start;
    start = n_items;
    while (n_items - start < RANDOM_ITEMS)
      send_message(pick_length(), 1'($urandom_range(1)));
    drain_digests();
  endtask

  initial begin
    hash_restart();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_message();
    test_unused_code();
    test_short_messages();
    test_back_pressure();
    test_streaming_no_gaps();
    test_random_messages();

    drain_digests();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Hashed %0d messages from %0d transactions: empty, single byte, padding edges,",
             n_msgs, n_items);
    $display("back-pressure and gap-free streaming; %0d digest words checked, %0d mismatches",
             n_words, n_errors);
    if (n_errors == 0 && digest_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
